// File: sv/acac_pkg.sv
// Shared types and constants for the adaptive cruise acceleration controller.
// Holds the register set, the captured tick, the microcode word and datapath widths.
// No dependencies.
package acac_pkg;

    // Datapath widths.
    localparam int FracW = 32;               // fraction bits of the law accumulator
    localparam int AccW  = 58;               // signed accumulator, holds 100 x law
    localparam int HiW   = AccW - FracW;     // integer part of the accumulator
    localparam int MulAW = 34;               // signed multiplier operand A
    localparam int MulBW = 17;               // signed multiplier operand B
    localparam int MulPW = MulAW + MulBW;    // product width

    localparam int StepW = 4;
    localparam logic [StepW-1:0] StepFinish = StepW'(11);

    localparam logic signed [HiW-1:0] CodeMax = HiW'(1023);
    localparam logic signed [HiW-1:0] CodeMin = HiW'(-1024);
    localparam logic signed [AccW-1:0] CodeBias = AccW'(64'sd5 <<< FracW);

    // Configuration register indexes.
    localparam logic [2:0] RegTimeGapBase      = 3'd0;
    localparam logic [2:0] RegStandstillDist   = 3'd1;
    localparam logic [2:0] RegGainSpeedError   = 3'd2;
    localparam logic [2:0] RegGainGapError     = 3'd3;
    localparam logic [2:0] RegGainClosingSpeed = 3'd4;
    localparam logic [2:0] RegAccelFloor       = 3'd5;
    localparam logic [2:0] RegAccelCeiling     = 3'd6;
    localparam logic [2:0] RegEngageSpeedMin   = 3'd7;

    typedef struct packed {
        logic [11:0]        headway_base;
        logic [7:0]         standstill_distance;
        logic [15:0]        gain_speed_error;
        logic [15:0]        gain_gap_error;
        logic [15:0]        gain_closing_speed;
        logic signed [10:0] accel_floor_centi;
        logic [9:0]         accel_ceiling_centi;
        logic [15:0]        engage_speed_min;
    } cfg_t;

    localparam cfg_t CfgReset = '{
        headway_base:        12'd768,
        standstill_distance: 8'd10,
        gain_speed_error:    16'd32768,
        gain_gap_error:      16'd13107,
        gain_closing_speed:  16'd2621,
        accel_floor_centi:   -11'sd500,
        accel_ceiling_centi: 10'd147,
        engage_speed_min:    16'd2816
    };

    // Numeric part of one accepted word.
    typedef struct packed {
        logic [15:0] own_speed;
        logic [15:0] gap_distance;
        logic [15:0] closing_speed;
        logic [15:0] target_speed;
        logic        raining;
    } item_t;

    typedef enum logic [1:0] {
        MA_OWN,
        MA_CLOSE,
        MA_ERR,
        MA_DIFF
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        MB_TG,
        MB_GCS,
        MB_GGE,
        MB_GSE
    } mul_b_sel_t;

    typedef enum logic [3:0] {
        ACC_HOLD,
        ACC_BASE,
        ACC_ADD_P,
        ACC_LOAD_P8,
        ACC_SUB_P,
        ACC_SEL_MIN,
        ACC_SHL2,
        ACC_ADD_T5,
        ACC_ADD_T6,
        ACC_CLAMP,
        ACC_ADD_BIAS
    } acc_op_t;

    typedef enum logic {
        JMP_NONE,
        JMP_IF_IDLE
    } jump_t;

    typedef struct packed {
        mul_a_sel_t       a_sel;
        mul_b_sel_t       b_sel;
        logic             mul_en;
        acc_op_t          acc_op;
        logic             save_flag;
        logic             save_lx;
        logic             save_t;
        jump_t            jmp;
        logic [StepW-1:0] target;
        logic             last;
    } ucode_t;

    localparam ucode_t UcNop = '{
        a_sel:     MA_OWN,
        b_sel:     MB_TG,
        mul_en:    1'b0,
        acc_op:    ACC_HOLD,
        save_flag: 1'b0,
        save_lx:   1'b0,
        save_t:    1'b0,
        jmp:       JMP_NONE,
        target:    '0,
        last:      1'b0
    };

endpackage

// File: sv/adaptive_cruise_accel_controller.sv
// Top level of the adaptive cruise acceleration controller (constant time gap).
// Holds the register set, engage latch, input capture and output register.
// Depends on acac_pkg, acac_seq and acac_dp.
//
// Usage:
//  - Config: cfg_wr_en/cfg_addr/cfg_wdata write one register per cycle, no wait.
//    Write only while the block is idle.
//  - Input: one word per control tick on s_valid/s_ready. The engage latch is
//    updated when the word is accepted.
//  - Output: one word per input on m_valid/m_ready: m_engaged, m_accel_valid
//    (same as m_engaged) and m_accel_code (0 when disengaged).
//  - Program: an engaged tick runs a 12-step microprogram on one shared
//    multiplier and one accumulator; no new word is accepted until the
//    program finishes, and s_ready returns in the same cycle that the result
//    is loaded into the output register. A disengaged tick jumps from step 0
//    straight to the last step.
//  - Stall: the output register holds its word until taken; a finished
//    program waits on its last step while the previous word is unread.
//  - Reset (aresetn low, synchronous): registers return to defaults, the
//    latch is disengaged and both channels are empty.
module adaptive_cruise_accel_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_own_speed,
    input  logic [15:0]        s_gap_distance,
    input  logic [15:0]        s_closing_speed,
    input  logic [15:0]        s_target_speed,
    input  logic               s_engage_request,
    input  logic               s_sensor_fault,
    input  logic               s_gas_pressed,
    input  logic               s_brake_pressed,
    input  logic               s_raining,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_engaged,
    output logic               m_accel_valid,
    output logic signed [10:0] m_accel_code
);

    acac_pkg::cfg_t     cfg_reg, cfg_next;
    acac_pkg::item_t    item_reg;
    logic               engaged_reg, engaged_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_engaged_reg;
    logic signed [10:0] m_code_reg;

    logic               accept;
    logic               ok;
    logic               out_free;
    logic               busy;
    logic               done;
    acac_pkg::ucode_t   ctrl;
    logic signed [10:0] dp_code;

    assign s_ready  = !busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign ok = s_engage_request && !s_sensor_fault && !s_gas_pressed && !s_brake_pressed;
    assign engaged_next = accept
        ? (ok && (engaged_reg || (s_own_speed >= cfg_reg.engage_speed_min)))
        : engaged_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                acac_pkg::RegTimeGapBase:      cfg_next.headway_base        = cfg_wdata[11:0];
                acac_pkg::RegStandstillDist:   cfg_next.standstill_distance = cfg_wdata[7:0];
                acac_pkg::RegGainSpeedError:   cfg_next.gain_speed_error    = cfg_wdata;
                acac_pkg::RegGainGapError:     cfg_next.gain_gap_error      = cfg_wdata;
                acac_pkg::RegGainClosingSpeed: cfg_next.gain_closing_speed  = cfg_wdata;
                acac_pkg::RegAccelFloor:       cfg_next.accel_floor_centi   = cfg_wdata[10:0];
                acac_pkg::RegAccelCeiling:     cfg_next.accel_ceiling_centi = cfg_wdata[9:0];
                acac_pkg::RegEngageSpeedMin:   cfg_next.engage_speed_min    = cfg_wdata;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= acac_pkg::CfgReset;
            engaged_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            engaged_reg <= engaged_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.own_speed     <= s_own_speed;
            item_reg.gap_distance  <= s_gap_distance;
            item_reg.closing_speed <= s_closing_speed;
            item_reg.target_speed  <= s_target_speed;
            item_reg.raining       <= s_raining;
        end
        if (done) begin
            m_engaged_reg <= engaged_reg;
            m_code_reg    <= engaged_reg ? dp_code : '0;
        end
    end

    acac_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (accept),
        .engaged_i  (engaged_reg),
        .out_free_i (out_free),
        .busy_o     (busy),
        .done_o     (done),
        .ctrl_o     (ctrl)
    );

    acac_dp u_dp (
        .aclk   (aclk),
        .ctrl_i (ctrl),
        .cfg_i  (cfg_reg),
        .item_i (item_reg),
        .code_o (dp_code)
    );

    assign m_valid       = m_valid_reg;
    assign m_engaged     = m_engaged_reg;
    assign m_accel_valid = m_engaged_reg;
    assign m_accel_code  = m_code_reg;

    a_idle_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_engaged_reg) |-> (m_code_reg == '0))
        else $error("disengaged word carries a nonzero code");

endmodule

// File: sv/acac_seq.sv
// Microcode sequencer: step counter, control store and conditional jump.
// Drives acac_dp with one control word per step. Depends on acac_pkg.
module acac_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start_i,
    input  logic             engaged_i,
    input  logic             out_free_i,
    output logic             busy_o,
    output logic             done_o,
    output acac_pkg::ucode_t ctrl_o
);

    logic                       busy_reg, busy_next;
    logic [acac_pkg::StepW-1:0] step_reg, step_next;
    acac_pkg::ucode_t           uc;
    logic                       jump_taken;

    // Control store.
    always_comb begin
        uc = acac_pkg::UcNop;
        case (step_reg)
            4'd0: begin
                uc.a_sel  = acac_pkg::MA_OWN;
                uc.b_sel  = acac_pkg::MB_TG;
                uc.mul_en = 1'b1;
                uc.acc_op = acac_pkg::ACC_BASE;
                uc.jmp    = acac_pkg::JMP_IF_IDLE;
                uc.target = acac_pkg::StepFinish;
            end
            4'd1: begin
                uc.a_sel  = acac_pkg::MA_CLOSE;
                uc.b_sel  = acac_pkg::MB_GCS;
                uc.mul_en = 1'b1;
                uc.acc_op = acac_pkg::ACC_ADD_P;
            end
            4'd2: begin
                uc.a_sel     = acac_pkg::MA_ERR;
                uc.b_sel     = acac_pkg::MB_GGE;
                uc.mul_en    = 1'b1;
                uc.acc_op    = acac_pkg::ACC_LOAD_P8;
                uc.save_flag = 1'b1;
            end
            4'd3: begin
                uc.a_sel  = acac_pkg::MA_DIFF;
                uc.b_sel  = acac_pkg::MB_GSE;
                uc.mul_en = 1'b1;
                uc.acc_op = acac_pkg::ACC_SUB_P;
            end
            4'd4: begin
                uc.acc_op  = acac_pkg::ACC_LOAD_P8;
                uc.save_lx = 1'b1;
            end
            4'd5: uc.acc_op = acac_pkg::ACC_SEL_MIN;
            4'd6: begin
                uc.acc_op = acac_pkg::ACC_SHL2;
                uc.save_t = 1'b1;
            end
            4'd7:  uc.acc_op = acac_pkg::ACC_ADD_T5;
            4'd8:  uc.acc_op = acac_pkg::ACC_ADD_T6;
            4'd9:  uc.acc_op = acac_pkg::ACC_CLAMP;
            4'd10: uc.acc_op = acac_pkg::ACC_ADD_BIAS;
            4'd11: uc.last   = 1'b1;
            default: uc = acac_pkg::UcNop;
        endcase
    end

    assign jump_taken = busy_reg && (uc.jmp == acac_pkg::JMP_IF_IDLE) && !engaged_i;
    assign done_o     = busy_reg && uc.last && out_free_i;
    assign busy_o     = busy_reg;
    assign ctrl_o     = busy_reg ? uc : acac_pkg::UcNop;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start_i) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg) begin
            if (done_o) begin
                busy_next = 1'b0;
            end else if (jump_taken) begin
                step_next = uc.target;
            end else if (!uc.last) begin
                step_next = step_reg + acac_pkg::StepW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    a_start_enters_step0: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |=> busy_reg && (step_reg == '0))
        else $error("sequencer did not start at step 0");

    a_done_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        done_o |=> !busy_reg)
        else $error("sequencer still busy after finish");

    a_step_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg <= acac_pkg::StepFinish)
        else $error("step counter left the program");

endmodule

// File: sv/acac_dp.sv
// Datapath: one shared signed multiplier, a wide accumulator and the
// clamp and code formatting. Controlled by acac_seq; depends on acac_pkg.
module acac_dp (
    input  logic               aclk,
    input  acac_pkg::ucode_t   ctrl_i,
    input  acac_pkg::cfg_t     cfg_i,
    input  acac_pkg::item_t    item_i,
    output logic signed [10:0] code_o
);

    logic signed [acac_pkg::AccW-1:0]  acc_reg, acc_next;
    logic signed [acac_pkg::AccW-1:0]  lx_reg;
    logic signed [acac_pkg::AccW-1:0]  t_reg;
    logic                              flag_reg;
    logic signed [acac_pkg::MulPW-1:0] p_reg, p_next;

    logic signed [acac_pkg::MulAW-1:0] mul_a;
    logic signed [acac_pkg::MulBW-1:0] mul_b;
    logic [12:0]                       tg;
    logic [16:0]                       speed_diff;
    logic [16:0]                       base_diff;
    logic signed [acac_pkg::AccW-1:0]  p_ext;
    logic signed [acac_pkg::HiW-1:0]   acc_hi;
    logic                              acc_frac_nz;
    logic signed [acac_pkg::HiW-1:0]   floor_ext;
    logic signed [acac_pkg::HiW-1:0]   ceil_ext;
    logic signed [acac_pkg::HiW-1:0]   quot;
    logic                              acc_pos;

    assign tg         = item_i.raining ? {cfg_i.headway_base, 1'b0}
                                       : {1'b0, cfg_i.headway_base};
    assign speed_diff = {1'b0, item_i.target_speed} - {1'b0, item_i.own_speed};
    assign base_diff  = {9'b0, cfg_i.standstill_distance} - {1'b0, item_i.gap_distance};

    always_comb begin
        case (ctrl_i.a_sel)
            acac_pkg::MA_OWN:
                mul_a = {{(acac_pkg::MulAW-16){1'b0}}, item_i.own_speed};
            acac_pkg::MA_CLOSE:
                mul_a = {{(acac_pkg::MulAW-16){1'b0}}, item_i.closing_speed};
            acac_pkg::MA_ERR:
                mul_a = acc_reg[acac_pkg::MulAW-1:0];
            acac_pkg::MA_DIFF:
                mul_a = {{(acac_pkg::MulAW-17){speed_diff[16]}}, speed_diff};
            default:
                mul_a = '0;
        endcase
        case (ctrl_i.b_sel)
            acac_pkg::MB_TG:  mul_b = {{(acac_pkg::MulBW-13){1'b0}}, tg};
            acac_pkg::MB_GCS: mul_b = {1'b0, cfg_i.gain_closing_speed};
            acac_pkg::MB_GGE: mul_b = {1'b0, cfg_i.gain_gap_error};
            acac_pkg::MB_GSE: mul_b = {1'b0, cfg_i.gain_speed_error};
            default:          mul_b = '0;
        endcase
    end

    assign p_next = ctrl_i.mul_en ? mul_a * mul_b : p_reg;
    assign p_ext  = {{(acac_pkg::AccW-acac_pkg::MulPW){p_reg[acac_pkg::MulPW-1]}}, p_reg};

    assign acc_hi      = acc_reg[acac_pkg::AccW-1:acac_pkg::FracW];
    assign acc_frac_nz = |acc_reg[acac_pkg::FracW-1:0];
    assign floor_ext   = {{(acac_pkg::HiW-11){cfg_i.accel_floor_centi[10]}},
                          cfg_i.accel_floor_centi};
    assign ceil_ext    = {{(acac_pkg::HiW-10){1'b0}}, cfg_i.accel_ceiling_centi};
    assign acc_pos     = !acc_reg[acac_pkg::AccW-1] && (acc_reg != '0);

    always_comb begin
        case (ctrl_i.acc_op)
            acac_pkg::ACC_HOLD:
                acc_next = acc_reg;
            acac_pkg::ACC_BASE:
                acc_next = {{(acac_pkg::AccW-33){base_diff[16]}}, base_diff, 16'b0};
            acac_pkg::ACC_ADD_P:
                acc_next = acc_reg + p_ext;
            acac_pkg::ACC_LOAD_P8:
                acc_next = {p_ext[acac_pkg::AccW-9:0], 8'b0};
            acac_pkg::ACC_SUB_P:
                acc_next = acc_reg - p_ext;
            acac_pkg::ACC_SEL_MIN:
                acc_next = (flag_reg || (lx_reg < acc_reg)) ? lx_reg : acc_reg;
            acac_pkg::ACC_SHL2:
                acc_next = {acc_reg[acac_pkg::AccW-3:0], 2'b0};
            acac_pkg::ACC_ADD_T5:
                acc_next = acc_reg + {t_reg[acac_pkg::AccW-6:0], 5'b0};
            acac_pkg::ACC_ADD_T6:
                acc_next = acc_reg + {t_reg[acac_pkg::AccW-7:0], 6'b0};
            acac_pkg::ACC_CLAMP: begin
                if (acc_hi < floor_ext) begin
                    acc_next = {floor_ext, {acac_pkg::FracW{1'b0}}};
                end else if ((acc_hi > ceil_ext) || ((acc_hi == ceil_ext) && acc_frac_nz)) begin
                    acc_next = {ceil_ext, {acac_pkg::FracW{1'b0}}};
                end else begin
                    acc_next = acc_reg;
                end
            end
            acac_pkg::ACC_ADD_BIAS:
                acc_next = acc_reg + acac_pkg::CodeBias;
            default:
                acc_next = acc_reg;
        endcase
    end

    // Truncate toward zero, then saturate to 11 bits.
    always_comb begin
        quot = acc_hi + {{(acac_pkg::HiW-1){1'b0}}, (acc_hi[acac_pkg::HiW-1] && acc_frac_nz)};
        if (quot > acac_pkg::CodeMax) begin
            code_o = acac_pkg::CodeMax[10:0];
        end else if (quot < acac_pkg::CodeMin) begin
            code_o = acac_pkg::CodeMin[10:0];
        end else begin
            code_o = quot[10:0];
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        p_reg   <= p_next;
        if (ctrl_i.save_flag) begin
            flag_reg <= acc_pos;
        end
        if (ctrl_i.save_lx) begin
            lx_reg <= acc_reg;
        end
        if (ctrl_i.save_t) begin
            t_reg <= acc_reg;
        end
    end

endmodule
